### hdl/xcd_pkg.sv
`default_nettype none
package xcd_pkg;

  typedef enum logic [2:0] {
    PH_FILE  = 3'd0,
    PH_EXTRA = 3'd1,
    PH_CHDR  = 3'd2,
    PH_DATA  = 3'd3,
    PH_PAD   = 3'd4,
    PH_DONE  = 3'd5,
    PH_ERR   = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    KIND_HDR    = 3'd0,
    KIND_DATA   = 3'd1,
    KIND_SKIP   = 3'd2,
    KIND_DONE   = 3'd3,
    KIND_ERR    = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    F_NONE    = 4'd0,
    F_MAGIC   = 4'd1,
    F_SIZE    = 4'd2,
    F_PASS    = 4'd3,
    F_FHXOR   = 4'd4,
    F_CHXOR   = 4'd5,
    F_DCHECK  = 4'd6,
    F_TYPE    = 4'd7,
    F_STORED  = 4'd8,
    F_OVERRUN = 4'd9,
    F_RAWTOT  = 4'd10
  } fault_e;

  localparam logic [31:0] MAGIC_XPKF = 32'h5850_4B46;
  localparam logic [7:0]  CT_STORED  = 8'd0;
  localparam logic [7:0]  CT_PACKED  = 8'd1;
  localparam logic [7:0]  CT_END     = 8'd15;
  localparam logic [0:0]  REG_MAX_RAW    = 1'b0;
  localparam logic [0:0]  REG_MAX_PACKED = 1'b1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  payload_byte;
    logic [7:0]  chunk_kind;
    logic [31:0] chunk_raw_size;
    logic        last_in_chunk;
    logic        chunk_good;
    logic [31:0] method_code;
    logic [3:0]  fault;
  } result_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_stream;
  } item_t;

endpackage
`default_nettype wire

### hdl/xcd_if.sv
`default_nettype none
interface xcd_in_if;
  logic             valid;
  logic             ready;
  xcd_pkg::item_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface xcd_out_if;
  logic             valid;
  logic             ready;
  xcd_pkg::result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface xcd_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### hdl/xcd_parser.sv
`default_nettype none
module xcd_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire xcd_pkg::item_t   item_i,
  input  wire logic [31:0]      max_raw_i,
  input  wire logic [31:0]      max_packed_i,
  output xcd_pkg::result_t      res_o
);

  xcd_pkg::phase_e phase_q, phase_d;
  logic [31:0] off_q, off_d, shift_q, shift_d;
  logic [7:0]  hx_q, hx_d, lx0_q, lx0_d, lx1_q, lx1_d;
  logic [15:0] chk_q, chk_d, extra_q, extra_d;
  logic [31:0] tp_q, tp_d, tr_q, tr_d, rs_q, rs_d, cp_q, cp_d, cr_q, cr_d;
  logic [31:0] left_q, left_d, meth_q, meth_d;
  logic [7:0]  ct_q, ct_d;
  logic        long_q, long_d;

  always_comb begin
    xcd_pkg::phase_e ph;
    logic [31:0] off, shv, idx, lft, pad32;
    logic [7:0]  b, t, hxv, l0, l1;
    logic [3:0]  f;
    logic [2:0]  kind;
    logic [7:0]  pb;
    logic        last, good, lng, endhdr, aftp, finc;
    logic [32:0] fend, rsum;
    logic [1:0]  pad;
    b = item_i.data_byte;
    phase_d = phase_q; off_d = off_q; shift_d = shift_q; hx_d = hx_q;
    lx0_d = lx0_q; lx1_d = lx1_q; chk_d = chk_q; tp_d = tp_q; tr_d = tr_q;
    rs_d = rs_q; cp_d = cp_q; cr_d = cr_q; ct_d = ct_q; left_d = left_q;
    long_d = long_q; extra_d = extra_q; meth_d = meth_q;
    if (item_i.new_stream) begin
      phase_d = xcd_pkg::PH_FILE; off_d = '0; shift_d = '0; hx_d = '0;
      lx0_d = '0; lx1_d = '0; chk_d = '0; tp_d = '0; tr_d = '0; rs_d = '0;
      cp_d = '0; cr_d = '0; ct_d = '0; left_d = '0; long_d = 1'b0;
      extra_d = '0; meth_d = '0;
    end
    ph = phase_d; off = off_d;
    kind = xcd_pkg::KIND_HDR; f = xcd_pkg::F_NONE; pb = '0; last = 1'b0;
    good = 1'b0; endhdr = 1'b0; aftp = 1'b0; finc = 1'b0;
    fend = {1'b0, tp_d} + 33'd8;
    shv = {shift_d[23:0], b};
    hxv = hx_d ^ b;
    lng = long_d;
    idx = '0; lft = left_d - 32'd1;
    l0 = lx0_d; l1 = lx1_d;
    if ((ph == xcd_pkg::PH_EXTRA || ph == xcd_pkg::PH_CHDR || ph == xcd_pkg::PH_DATA
         || ph == xcd_pkg::PH_PAD) && {1'b0, off} >= fend) begin
      f = xcd_pkg::F_OVERRUN;
    end else begin
      case (ph)
        xcd_pkg::PH_FILE: begin
          hx_d = hxv; shift_d = shv;
          if (off == 32'd3) begin
            if (shv != xcd_pkg::MAGIC_XPKF) f = xcd_pkg::F_MAGIC;
          end else if (off == 32'd7) tp_d = shv;
          else if (off == 32'd11) meth_d = shv;
          else if (off == 32'd15) begin
            tr_d = shv;
            if (shv == '0 || tp_d == '0 || shv > max_raw_i || tp_d > max_packed_i)
              f = xcd_pkg::F_SIZE;
          end else if (off == 32'd32) begin
            chk_d = {8'd0, b}; long_d = b[0];
            if (b[1]) f = xcd_pkg::F_PASS;
          end else if (off == 32'd35) begin
            if (hxv != '0) f = xcd_pkg::F_FHXOR;
            else if (!chk_d[2]) begin
              phase_d = xcd_pkg::PH_CHDR; left_d = lng ? 32'd12 : 32'd8;
              hx_d = '0; shift_d = '0;
            end
          end else if (off == 32'd37) begin
            extra_d = shv[15:0];
            if (shv[15:0] != '0) begin
              phase_d = xcd_pkg::PH_EXTRA; left_d = {16'd0, shv[15:0]};
            end else begin
              phase_d = xcd_pkg::PH_CHDR; left_d = lng ? 32'd12 : 32'd8;
              hx_d = '0; shift_d = '0;
            end
          end
        end
        xcd_pkg::PH_EXTRA: begin
          kind = xcd_pkg::KIND_SKIP; left_d = lft;
          if (lft == '0) begin
            phase_d = xcd_pkg::PH_CHDR; left_d = lng ? 32'd12 : 32'd8;
            hx_d = '0; shift_d = '0;
          end
        end
        xcd_pkg::PH_CHDR: begin
          idx = (lng ? 32'd12 : 32'd8) - left_d;
          hx_d = hxv; shift_d = shv;
          if (idx == 32'd0) ct_d = b;
          else if (idx == 32'd3) chk_d = shv[15:0];
          if (lng) begin
            if (idx == 32'd7) cp_d = shv;
            else if (idx == 32'd11) cr_d = shv;
          end else begin
            if (idx == 32'd5) cp_d = {16'd0, shv[15:0]};
            else if (idx == 32'd7) cr_d = {16'd0, shv[15:0]};
          end
          left_d = lft;
          endhdr = (lft == '0);
        end
        xcd_pkg::PH_DATA: begin
          idx = cp_d - left_d;
          if (idx[0]) l1 = lx1_d ^ b; else l0 = lx0_d ^ b;
          lx0_d = l0; lx1_d = l1;
          left_d = lft; kind = xcd_pkg::KIND_DATA; pb = b;
          if (lft == '0) begin
            last = 1'b1;
            if (l0 == chk_d[15:8] && l1 == chk_d[7:0]) begin
              good = 1'b1; aftp = 1'b1;
            end else f = xcd_pkg::F_DCHECK;
          end
        end
        xcd_pkg::PH_PAD: begin
          kind = xcd_pkg::KIND_SKIP; left_d = lft;
          finc = (lft == '0);
        end
        xcd_pkg::PH_DONE: kind = xcd_pkg::KIND_DONE;
        default: begin
          kind = xcd_pkg::KIND_ERR; f = shift_d[3:0];
        end
      endcase
    end
    t = ct_d;
    rsum = {1'b0, rs_d} + {1'b0, cr_d};
    if (endhdr) begin
      if (hx_d != '0) f = xcd_pkg::F_CHXOR;
      else if (t != xcd_pkg::CT_STORED && t != xcd_pkg::CT_PACKED && t != xcd_pkg::CT_END)
        f = xcd_pkg::F_TYPE;
      else if (t == xcd_pkg::CT_STORED && cr_d != '0 && cr_d != cp_d) f = xcd_pkg::F_STORED;
      else if (rsum > {1'b0, tr_d}) f = xcd_pkg::F_OVERRUN;
      else begin
        rs_d = rsum[31:0]; lx0_d = '0; lx1_d = '0;
        if (cp_d != '0) begin
          phase_d = xcd_pkg::PH_DATA; left_d = cp_d;
        end else aftp = 1'b1;
      end
    end
    pad32 = 32'd0 - cp_d;
    pad = pad32[1:0];
    if (aftp) begin
      if (pad != 2'd0) begin
        phase_d = xcd_pkg::PH_PAD; left_d = {30'd0, pad};
      end else finc = 1'b1;
    end
    if (finc) begin
      if (ct_d == xcd_pkg::CT_END) begin
        if (rs_d != tr_d) f = xcd_pkg::F_RAWTOT;
        else phase_d = xcd_pkg::PH_DONE;
      end else begin
        phase_d = xcd_pkg::PH_CHDR; left_d = lng ? 32'd12 : 32'd8;
        hx_d = '0; shift_d = '0;
      end
    end
    if (f != xcd_pkg::F_NONE) begin
      phase_d = xcd_pkg::PH_ERR; shift_d = {28'd0, f};
      kind = xcd_pkg::KIND_ERR; pb = '0; last = 1'b0; good = 1'b0;
    end
    off_d = off + 32'd1;
    res_o.kind = kind; res_o.payload_byte = pb; res_o.chunk_kind = ct_d;
    res_o.chunk_raw_size = cr_d; res_o.last_in_chunk = last; res_o.chunk_good = good;
    res_o.method_code = meth_d; res_o.fault = f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= xcd_pkg::PH_FILE; off_q <= '0; shift_q <= '0; hx_q <= '0;
      lx0_q <= '0; lx1_q <= '0; chk_q <= '0; tp_q <= '0; tr_q <= '0; rs_q <= '0;
      cp_q <= '0; cr_q <= '0; ct_q <= '0; left_q <= '0; long_q <= 1'b0;
      extra_q <= '0; meth_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d; off_q <= off_d; shift_q <= shift_d; hx_q <= hx_d;
      lx0_q <= lx0_d; lx1_q <= lx1_d; chk_q <= chk_d; tp_q <= tp_d; tr_q <= tr_d;
      rs_q <= rs_d; cp_q <= cp_d; cr_q <= cr_d; ct_q <= ct_d; left_q <= left_d;
      long_q <= long_d; extra_q <= extra_d; meth_q <= meth_d;
    end
  end

endmodule
`default_nettype wire

### hdl/xpk_container_deframer.sv
`default_nettype none
// Byte-serial container deframer: one request per file byte, one result per request.
// A byte is taken into an input register, parsed combinationally and the result held
// in an output register, so a new byte is accepted every cycle while the result side
// keeps up; throughput is then one byte per clock.
module xpk_container_deframer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  xcd_in_if.sink    in_i,
  xcd_out_if.source out_o,
  xcd_cfg_if.sink   cfg_i
);

  logic [31:0] max_raw_q, max_packed_q;
  logic        iv_q, ov_q, step;
  xcd_pkg::item_t   item_q;
  xcd_pkg::result_t res, res_q;

  assign cfg_i.ready = 1'b1;
  assign step        = iv_q && (!ov_q || out_o.ready);
  assign in_i.ready  = !iv_q || step;
  assign out_o.valid = ov_q;
  assign out_o.payload = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_raw_q <= 32'd16777216; max_packed_q <= 32'd16777216;
      iv_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        if (cfg_i.index == xcd_pkg::REG_MAX_RAW) max_raw_q <= cfg_i.data;
        else max_packed_q <= cfg_i.data;
      end
      if (in_i.ready) iv_q <= in_i.valid;
      if (step) ov_q <= 1'b1;
      else if (out_o.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) item_q <= in_i.payload;
    if (step) res_q <= res;
  end

  xcd_parser u_parser (
    .clk_i(clk_i), .rst_ni(rst_ni), .step_i(step), .item_i(item_q),
    .max_raw_i(max_raw_q), .max_packed_i(max_packed_q), .res_o(res)
  );

endmodule
`default_nettype wire

### hdl/xcd_checker.sv
`default_nettype none
module xcd_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire xcd_pkg::result_t out_payload_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("hold");
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_payload_i.fault != xcd_pkg::F_NONE |->
    out_payload_i.kind == xcd_pkg::KIND_ERR) else $error("err");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_payload_i.chunk_good |-> out_payload_i.last_in_chunk)
    else $error("good");
  a_pb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_payload_i.kind != xcd_pkg::KIND_DATA |->
    out_payload_i.payload_byte == 8'd0)
    else $error("pb");
endmodule

bind xpk_container_deframer xcd_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready), .out_payload_i(out_o.payload)
);
`default_nettype wire

### tb/tb_xpk_container_deframer.sv
`default_nettype none
module tb_xpk_container_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    FM_GOOD, FM_FLIP, FM_RAWTOT, FM_OVERRUN, FM_TYPE, FM_PASS, FM_TRUNC, FM_NOISE
  } file_mode_e;

  localparam int WATCHDOG_LIMIT = 4000;

  logic clk_i;
  logic rst_ni;

  xcd_in_if  in_if ();
  xcd_out_if out_if ();
  xcd_cfg_if cfg_if ();

  xpk_container_deframer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  xcd_pkg::item_t   byte_q[$];
  xcd_pkg::result_t result_q[$];
  int      mismatches;
  int      bytes_queued;
  bit      gaps_on;
  bit      stalls_on;
  int      send_gap;
  int      recv_stall;
  int      quiet_cycles;

  // Parser image kept alongside the block.
  logic [31:0] lim_raw, lim_packed;
  xcd_pkg::phase_e ps_phase;
  logic [31:0] ps_off, ps_shift;
  logic [7:0]  ps_hxor;
  logic [7:0]  ps_lane [2];
  logic [15:0] ps_check;
  logic [31:0] ps_tot_packed, ps_tot_raw, ps_raw_sum, ps_ch_packed, ps_ch_raw;
  logic [7:0]  ps_ch_type;
  logic [31:0] ps_left;
  logic        ps_long;
  logic [15:0] ps_extra;
  logic [31:0] ps_method;

  function automatic void restart_parser();
    ps_phase = xcd_pkg::PH_FILE;
    ps_off = '0;
    ps_shift = '0;
    ps_hxor = '0;
    ps_lane[0] = '0;
    ps_lane[1] = '0;
    ps_check = '0;
    ps_tot_packed = '0;
    ps_tot_raw = '0;
    ps_raw_sum = '0;
    ps_ch_packed = '0;
    ps_ch_raw = '0;
    ps_ch_type = '0;
    ps_left = '0;
    ps_long = 1'b0;
    ps_extra = '0;
    ps_method = '0;
  endfunction

  function automatic void open_chunk_header();
    ps_phase = xcd_pkg::PH_CHDR;
    ps_left = ps_long ? 32'd12 : 32'd8;
    ps_hxor = '0;
    ps_shift = '0;
  endfunction

  function automatic xcd_pkg::fault_e close_chunk();
    if (ps_ch_type == xcd_pkg::CT_END) begin
      if (ps_raw_sum != ps_tot_raw) return xcd_pkg::F_RAWTOT;
      ps_phase = xcd_pkg::PH_DONE;
      return xcd_pkg::F_NONE;
    end
    open_chunk_header();
    return xcd_pkg::F_NONE;
  endfunction

  function automatic xcd_pkg::fault_e close_payload();
    logic [31:0] pad;
    pad = (32'd0 - ps_ch_packed) & 32'd3;
    if (pad != 0) begin
      ps_phase = xcd_pkg::PH_PAD;
      ps_left = pad;
      return xcd_pkg::F_NONE;
    end
    return close_chunk();
  endfunction

  function automatic xcd_pkg::fault_e check_chunk_header();
    if (ps_hxor != 0) return xcd_pkg::F_CHXOR;
    if (ps_ch_type != xcd_pkg::CT_STORED && ps_ch_type != xcd_pkg::CT_PACKED &&
        ps_ch_type != xcd_pkg::CT_END)
      return xcd_pkg::F_TYPE;
    if (ps_ch_type == xcd_pkg::CT_STORED && ps_ch_raw != 0 && ps_ch_raw != ps_ch_packed)
      return xcd_pkg::F_STORED;
    if ({1'b0, ps_raw_sum} + {1'b0, ps_ch_raw} > {1'b0, ps_tot_raw})
      return xcd_pkg::F_OVERRUN;
    ps_raw_sum = ps_raw_sum + ps_ch_raw;
    ps_lane[0] = '0;
    ps_lane[1] = '0;
    if (ps_ch_packed != 0) begin
      ps_phase = xcd_pkg::PH_DATA;
      ps_left = ps_ch_packed;
      return xcd_pkg::F_NONE;
    end
    return close_payload();
  endfunction

  function automatic xcd_pkg::result_t parse_byte(xcd_pkg::item_t it);
    xcd_pkg::result_t r;
    logic [7:0]  b;
    logic [31:0] off, idx;
    logic [32:0] file_end;
    xcd_pkg::kind_e  k;
    xcd_pkg::fault_e f;
    logic [7:0]  pb;
    logic        last, good;
    b = it.data_byte;
    k = xcd_pkg::KIND_HDR;
    f = xcd_pkg::F_NONE;
    pb = '0;
    last = 1'b0;
    good = 1'b0;
    if (it.new_stream) restart_parser();
    off = ps_off;
    file_end = {1'b0, ps_tot_packed} + 33'd8;
    if ((ps_phase == xcd_pkg::PH_EXTRA || ps_phase == xcd_pkg::PH_CHDR ||
         ps_phase == xcd_pkg::PH_DATA || ps_phase == xcd_pkg::PH_PAD) &&
        {1'b0, off} >= file_end) begin
      f = xcd_pkg::F_OVERRUN;
    end else if (ps_phase == xcd_pkg::PH_FILE) begin
      ps_hxor ^= b;
      ps_shift = {ps_shift[23:0], b};
      if (off == 3) begin
        if (ps_shift != xcd_pkg::MAGIC_XPKF) f = xcd_pkg::F_MAGIC;
      end else if (off == 7) begin
        ps_tot_packed = ps_shift;
      end else if (off == 11) begin
        ps_method = ps_shift;
      end else if (off == 15) begin
        ps_tot_raw = ps_shift;
        if (ps_tot_raw == 0 || ps_tot_packed == 0 || ps_tot_raw > lim_raw ||
            ps_tot_packed > lim_packed) f = xcd_pkg::F_SIZE;
      end else if (off == 32) begin
        ps_check = {8'd0, b};
        ps_long = b[0];
        if (b[1]) f = xcd_pkg::F_PASS;
      end else if (off == 35) begin
        if (ps_hxor != 0) f = xcd_pkg::F_FHXOR;
        else if (!ps_check[2]) open_chunk_header();
      end else if (off == 37) begin
        ps_extra = ps_shift[15:0];
        if (ps_extra != 0) begin
          ps_phase = xcd_pkg::PH_EXTRA;
          ps_left = {16'd0, ps_extra};
        end else begin
          open_chunk_header();
        end
      end
    end else if (ps_phase == xcd_pkg::PH_EXTRA) begin
      k = xcd_pkg::KIND_SKIP;
      ps_left--;
      if (ps_left == 0) open_chunk_header();
    end else if (ps_phase == xcd_pkg::PH_CHDR) begin
      idx = (ps_long ? 32'd12 : 32'd8) - ps_left;
      ps_hxor ^= b;
      ps_shift = {ps_shift[23:0], b};
      if (idx == 0) ps_ch_type = b;
      else if (idx == 3) ps_check = ps_shift[15:0];
      if (ps_long) begin
        if (idx == 7) ps_ch_packed = ps_shift;
        else if (idx == 11) ps_ch_raw = ps_shift;
      end else begin
        if (idx == 5) ps_ch_packed = {16'd0, ps_shift[15:0]};
        else if (idx == 7) ps_ch_raw = {16'd0, ps_shift[15:0]};
      end
      ps_left--;
      if (ps_left == 0) f = check_chunk_header();
    end else if (ps_phase == xcd_pkg::PH_DATA) begin
      idx = ps_ch_packed - ps_left;
      ps_lane[idx[0]] ^= b;
      ps_left--;
      k = xcd_pkg::KIND_DATA;
      pb = b;
      if (ps_left == 0) begin
        last = 1'b1;
        if (ps_lane[0] == ps_check[15:8] && ps_lane[1] == ps_check[7:0]) begin
          good = 1'b1;
          f = close_payload();
        end else begin
          f = xcd_pkg::F_DCHECK;
        end
      end
    end else if (ps_phase == xcd_pkg::PH_PAD) begin
      k = xcd_pkg::KIND_SKIP;
      ps_left--;
      if (ps_left == 0) f = close_chunk();
    end else if (ps_phase == xcd_pkg::PH_DONE) begin
      k = xcd_pkg::KIND_DONE;
    end else begin
      k = xcd_pkg::KIND_ERR;
      f = xcd_pkg::fault_e'(ps_shift[3:0]);
    end
    if (f != xcd_pkg::F_NONE) begin
      ps_phase = xcd_pkg::PH_ERR;
      ps_shift = {28'd0, f};
      k = xcd_pkg::KIND_ERR;
      pb = '0;
      last = 1'b0;
      good = 1'b0;
    end
    ps_off = off + 32'd1;
    r.kind = k;
    r.payload_byte = pb;
    r.chunk_kind = ps_ch_type;
    r.chunk_raw_size = ps_ch_raw;
    r.last_in_chunk = last;
    r.chunk_good = good;
    r.method_code = ps_method;
    r.fault = f;
    return r;
  endfunction

  task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch, got %0h expected %0h", $realtime, field, got, want);
    mismatches++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.payload <= '0;
      send_gap <= 0;
    end else if (in_if.valid && !in_if.ready) begin
    end else if (send_gap != 0) begin
      in_if.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (byte_q.size() > 0) begin
      in_if.valid <= 1'b1;
      in_if.payload <= byte_q.pop_front();
      send_gap <= gaps_on ? $urandom_range(0, 18) : 0;
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) result_q.push_back(parse_byte(in_if.payload));
  end

  // Result monitor with its own back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: result with none expected", $realtime);
          mismatches++;
        end else begin
          xcd_pkg::result_t got, want;
          got = out_if.payload;
          want = result_q.pop_front();
          if (got.kind !== want.kind) flag_mismatch("kind", got.kind, want.kind);
          if (got.payload_byte !== want.payload_byte)
            flag_mismatch("payload_byte", got.payload_byte, want.payload_byte);
          if (got.chunk_kind !== want.chunk_kind)
            flag_mismatch("chunk_kind", got.chunk_kind, want.chunk_kind);
          if (got.chunk_raw_size !== want.chunk_raw_size)
            flag_mismatch("chunk_raw_size", got.chunk_raw_size, want.chunk_raw_size);
          if (got.last_in_chunk !== want.last_in_chunk)
            flag_mismatch("last_in_chunk", got.last_in_chunk, want.last_in_chunk);
          if (got.chunk_good !== want.chunk_good)
            flag_mismatch("chunk_good", got.chunk_good, want.chunk_good);
          if (got.method_code !== want.method_code)
            flag_mismatch("method_code", got.method_code, want.method_code);
          if (got.fault !== want.fault) flag_mismatch("fault", got.fault, want.fault);
        end
      end
      if (out_if.ready && !out_if.valid) begin
      end else if (out_if.valid && out_if.ready) begin
        recv_stall <= stalls_on ? $urandom_range(0, 18) : 0;
        out_if.ready <= !stalls_on;
      end else if (recv_stall != 0) begin
        recv_stall <= recv_stall - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_limit(logic idx, logic [31:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == xcd_pkg::REG_MAX_RAW) lim_raw = value;
    else lim_packed = value;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || result_q.size() != 0 || in_if.valid) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic queue_bytes(logic [7:0] bytes[$], bit noisy);
    xcd_pkg::item_t it;
    foreach (bytes[i]) begin
      it.data_byte = bytes[i];
      it.new_stream = (i == 0) || (noisy && $urandom_range(0, 7) == 0);
      byte_q.push_back(it);
      bytes_queued++;
    end
  endtask

  task automatic queue_file(file_mode_e mode);
    logic [7:0]  f[$], body[$], hdr[$], pl[$];
    logic [7:0]  l0, l1, t, x;
    logic [31:0] tpk, traw, pk, rw, sum;
    bit          lng, ext;
    int          nch, el;
    lng = $urandom_range(0, 1);
    ext = $urandom_range(0, 3) == 0;
    nch = $urandom_range(0, 3);
    sum = 0;
    if (mode == FM_NOISE) begin
      repeat ($urandom_range(1, 20)) f.push_back($urandom_range(0, 255));
      queue_bytes(f, 1'b1);
      return;
    end
    if (ext) begin
      el = $urandom_range(0, 5);
      body.push_back(8'd0);
      body.push_back(el[7:0]);
      repeat (el) body.push_back($urandom_range(0, 255));
    end
    for (int c = 0; c <= nch; c++) begin
      pl = {};
      if (c == nch) begin
        t = xcd_pkg::CT_END;
        pk = $urandom_range(0, 3);
        rw = $urandom_range(0, 5);
        if (sum + rw == 0) rw = 1;
      end else begin
        t = $urandom_range(0, 1) ? xcd_pkg::CT_PACKED : xcd_pkg::CT_STORED;
        if (mode == FM_TYPE && c == 0) t = $urandom_range(2, 14);
        pk = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
        if (t == xcd_pkg::CT_STORED) rw = ($urandom_range(0, 3) == 0) ? 0 : pk;
        else rw = $urandom_range(0, 80);
      end
      sum += rw;
      l0 = 0;
      l1 = 0;
      for (int i = 0; i < pk; i++) begin
        pl.push_back($urandom_range(0, 255));
        if (i % 2 == 0) l0 ^= pl[i];
        else l1 ^= pl[i];
      end
      hdr = {t, 8'd0, l0, l1};
      if (lng) hdr = {hdr, pk[31:24], pk[23:16], pk[15:8], pk[7:0],
                      rw[31:24], rw[23:16], rw[15:8], rw[7:0]};
      else hdr = {hdr, pk[15:8], pk[7:0], rw[15:8], rw[7:0]};
      x = 0;
      foreach (hdr[i]) x ^= hdr[i];
      hdr[1] = x;
      body = {body, hdr, pl};
      repeat ((4 - pk % 4) % 4) body.push_back($urandom_range(0, 255));
    end
    tpk = 36 + body.size() - 8;
    traw = sum;
    if (mode == FM_OVERRUN) tpk = tpk - $urandom_range(1, 10);
    if (mode == FM_RAWTOT) begin
      if ($urandom_range(0, 1) || sum < 2) traw = sum + $urandom_range(1, 3);
      else traw = sum - 1;
    end
    f = {8'h58, 8'h50, 8'h4B, 8'h46, tpk[31:24], tpk[23:16], tpk[15:8], tpk[7:0]};
    repeat (4) f.push_back($urandom_range(0, 255));
    f = {f, traw[31:24], traw[23:16], traw[15:8], traw[7:0]};
    repeat (16) f.push_back($urandom_range(0, 255));
    f.push_back({3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), ext,
                 mode == FM_PASS, lng});
    repeat (2) f.push_back($urandom_range(0, 255));
    x = 0;
    foreach (f[i]) x ^= f[i];
    f.push_back(x);
    f = {f, body};
    if (mode == FM_FLIP) begin
      el = $urandom_range(0, f.size() - 1);
      f[el][$urandom_range(0, 7)] ^= 1'b1;
    end
    if (mode == FM_TRUNC) f = f[0:$urandom_range(1, f.size() - 1)];
    else repeat ($urandom_range(0, 3)) f.push_back($urandom_range(0, 255));
    queue_bytes(f, 1'b0);
  endtask

  task automatic run_files(int amount);
    int stop_at, roll;
    stop_at = bytes_queued + amount;
    while (bytes_queued < stop_at) begin
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 15) == 0) gaps_on = ~gaps_on;
      if ($urandom_range(0, 15) == 0) stalls_on = ~stalls_on;
      if (roll < 60) queue_file(FM_GOOD);
      else if (roll < 72) queue_file(FM_FLIP);
      else if (roll < 77) queue_file(FM_RAWTOT);
      else if (roll < 82) queue_file(FM_OVERRUN);
      else if (roll < 86) queue_file(FM_TYPE);
      else if (roll < 89) queue_file(FM_PASS);
      else if (roll < 95) queue_file(FM_TRUNC);
      else queue_file(FM_NOISE);
      while (byte_q.size() > 40) @(posedge clk_i);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = xcd_pkg::REG_MAX_RAW;
    cfg_if.data = '0;
    mismatches = 0;
    bytes_queued = 0;
    quiet_cycles = 0;
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    lim_raw = 32'd16777216;
    lim_packed = 32'd16777216;
    restart_parser();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int m = FM_GOOD; m <= FM_NOISE; m++) queue_file(file_mode_e'(m));
    run_files(250);
    wait_drained();

    write_limit(xcd_pkg::REG_MAX_RAW, 32'hFFFF_FFFF);
    write_limit(xcd_pkg::REG_MAX_PACKED, 32'hFFFF_FFFF);
    run_files(300);
    wait_drained();

    write_limit(xcd_pkg::REG_MAX_RAW, 32'd1);
    write_limit(xcd_pkg::REG_MAX_PACKED, 32'd1);
    run_files(80);
    wait_drained();

    write_limit(xcd_pkg::REG_MAX_RAW, $urandom_range(30, 200));
    write_limit(xcd_pkg::REG_MAX_PACKED, $urandom_range(40, 250));
    run_files(280);
    wait_drained();

    write_limit(xcd_pkg::REG_MAX_RAW, $urandom_range(300, 32'h7FFF_FFFF));
    write_limit(xcd_pkg::REG_MAX_PACKED, $urandom_range(300, 32'h7FFF_FFFF));
    run_files(280);
    wait_drained();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
hdl/xcd_pkg.sv
hdl/xcd_if.sv
hdl/xcd_parser.sv
hdl/xpk_container_deframer.sv
hdl/xcd_checker.sv
tb/tb_xpk_container_deframer.sv
